@@ design/mrsp_pkg.sv @@
package mrsp_pkg;

   localparam int unsigned BYTE_W = 8;
   localparam int unsigned CHAN_W = 4;
   localparam int unsigned KIND_W = 3;
   localparam int unsigned DATA_W = 7;

   // Message kind; a channel status high nibble minus 8 maps straight onto it,
   // and a system status (0xF) lands on KIND_IDLE.
   typedef enum logic [KIND_W-1:0] {
      KIND_NOTE_OFF   = 3'd0,
      KIND_NOTE_ON    = 3'd1,
      KIND_AFTERTOUCH = 3'd2,
      KIND_CONTROL    = 3'd3,
      KIND_PROGRAM    = 3'd4,
      KIND_PRESSURE   = 3'd5,
      KIND_PITCH_BEND = 3'd6,
      KIND_IDLE       = 3'd7
   } msg_kind_type;

   typedef struct packed {
      logic [CHAN_W-1:0] channel;
      logic [KIND_W-1:0] kind;
      logic [DATA_W-1:0] first_data;
      logic [DATA_W-1:0] second_data;
   } event_type;

endpackage

@@ design/mrsp_decode.sv @@
module mrsp_decode (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          byte_fire,
   input  logic [mrsp_pkg::BYTE_W-1:0]   byte_data,
   output logic                          evt_valid,
   output mrsp_pkg::event_type           evt
);
   import mrsp_pkg::*;

   logic [CHAN_W-1:0] running_channel_ff, running_channel_in;
   msg_kind_type      running_type_ff, running_type_in;
   logic              have_first_ff, have_first_in;
   logic [DATA_W-1:0] held_first_ff, held_first_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         running_channel_ff <= '0;
         running_type_ff    <= KIND_IDLE;
         have_first_ff      <= 1'b0;
      end else begin
         running_channel_ff <= running_channel_in;
         running_type_ff    <= running_type_in;
         have_first_ff      <= have_first_in;
      end
      held_first_ff <= held_first_in;
   end

   always_comb begin
      running_channel_in = running_channel_ff;
      running_type_in    = running_type_ff;
      have_first_in      = have_first_ff;
      held_first_in      = held_first_ff;
      evt_valid          = 1'b0;
      evt.channel        = running_channel_ff;
      evt.kind           = running_type_ff;
      evt.first_data     = byte_data[DATA_W-1:0];
      evt.second_data    = '0;

      if (byte_fire) begin
         if (byte_data[BYTE_W-1]) begin
            // any status restarts collection; 0xFx goes idle
            running_channel_in = byte_data[CHAN_W-1:0];
            running_type_in    = msg_kind_type'(byte_data[BYTE_W-2:CHAN_W]);
            have_first_in      = 1'b0;
         end else if (running_type_ff != KIND_IDLE) begin
            if (running_type_ff inside {KIND_PROGRAM, KIND_PRESSURE}) begin
               evt_valid = 1'b1;
            end else if (!have_first_ff) begin
               held_first_in = byte_data[DATA_W-1:0];
               have_first_in = 1'b1;
            end else begin
               evt_valid       = 1'b1;
               evt.first_data  = held_first_ff;
               evt.second_data = byte_data[DATA_W-1:0];
               have_first_in   = 1'b0;
            end
         end
      end
   end

endmodule

@@ design/mrsp_out_reg.sv @@
module mrsp_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load_valid,
   input  mrsp_pkg::event_type  load_evt,
   output logic                 out_free,
   output logic                 out_valid,
   input  logic                 out_ready,
   output mrsp_pkg::event_type  out_evt
);
   import mrsp_pkg::*;

   logic      valid_ff, valid_in;
   event_type evt_ff, evt_in;

   // register frees in the same cycle its beat is taken
   assign out_free = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff && !out_ready;
      evt_in   = evt_ff;
      if (out_free && load_valid) begin
         valid_in = 1'b1;
         evt_in   = load_evt;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      evt_ff <= evt_in;
   end

   assign out_valid = valid_ff;
   assign out_evt   = evt_ff;

endmodule

@@ design/midi_running_status_parser_core.sv @@
// MIDI channel-message parser with running status.
// Input channel (req_*): one received MIDI byte per beat. Status bytes set the
// running channel and message kind; data bytes are collected under it.
// Result channel (rsp_*): one beat per completed message with channel, kind
// (0 note off .. 6 pitch bend), first data byte and second data byte (0 for
// program change and channel pressure). Status bytes, first bytes of two-byte
// messages and data bytes while idle give no beat.
// Path: input register, combinational decode, then the result register.
// Throughput: one byte per cycle while rsp_ready is high; the input register
// and the result register each hold one beat and the only loop is the
// running-status update. When the receiver stalls, the result register holds its
// beat; the input register then fills and req_ready drops until rsp_ready returns.
// Reset: running kind goes idle (data bytes dropped until a channel status),
// channel 0, no pending first byte, both registers empty.
module midi_running_status_parser_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [mrsp_pkg::BYTE_W-1:0]        req_midi_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mrsp_pkg::CHAN_W-1:0]        rsp_event_channel,
   output logic [mrsp_pkg::KIND_W-1:0]        rsp_event_type,
   output logic [mrsp_pkg::DATA_W-1:0]        rsp_first_data,
   output logic [mrsp_pkg::DATA_W-1:0]        rsp_second_data
);
   import mrsp_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;
   logic              out_free;
   logic              advance;
   logic              evt_valid;
   event_type         evt;
   event_type         out_evt;

   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   always_comb begin
      in_valid_in = in_valid_ff && !advance;
      in_byte_in  = in_byte_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_midi_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_byte_ff <= in_byte_in;
   end

   mrsp_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .byte_fire (advance),
      .byte_data (in_byte_ff),
      .evt_valid (evt_valid),
      .evt       (evt)
   );

   mrsp_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load_valid (advance && evt_valid),
      .load_evt   (evt),
      .out_free   (out_free),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_evt    (out_evt)
   );

   assign rsp_event_channel = out_evt.channel;
   assign rsp_event_type    = out_evt.kind;
   assign rsp_first_data    = out_evt.first_data;
   assign rsp_second_data   = out_evt.second_data;

endmodule
